// File: rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ssd_pkg.sv
// types, codes and width helpers for the sample standard deviation block
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int unsigned DEF_MAX_SAMPLES = 4096;
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned DEV_W           = 16;
  localparam int unsigned COUNT_OUT_W     = 13;
  localparam int unsigned S_TDATA_W       = 16;
  localparam int unsigned M_TDATA_W       = 32;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SHORT    = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_NQ,
    OP_LOAD_SS,
    OP_LOAD_DEN,
    OP_MUL_STEP,
    OP_LOAD_DIV,
    OP_DIV_STEP,
    OP_LOAD_SQRT,
    OP_SQRT_STEP,
    OP_WRITE_OUT
  } dp_op_t;

  typedef struct packed {
    logic   take;
    dp_op_t op;
  } dp_cmd_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_SETTLE,
    ST_MUL_NQ,
    ST_MUL_SS,
    ST_MUL_DEN,
    ST_DIV,
    ST_SQRT,
    ST_RESULT
  } ctrl_state_t;

  // sample counter, holds the maximum itself
  function automatic int cnt_w(int max_s);
    return $clog2(max_s + 1);
  endfunction

  // magnitude of the running sum
  function automatic int mag_w(int max_s);
    return 16 + $clog2(max_s);
  endfunction

  // signed running sum
  function automatic int sum_w(int max_s);
    return 17 + $clog2(max_s);
  endfunction

  // running sum of squares
  function automatic int sq_w(int max_s);
    return 31 + $clog2(max_s);
  endfunction

  // n*Q and S*S products
  function automatic int prod_w(int max_s);
    return 31 + 2 * $clog2(max_s);
  endfunction

endpackage

// File: rtl/ssd_ctrl.sv
// sequencer for accumulation and the final multiply, divide and square root
`timescale 1ns / 1ps

module ssd_ctrl #(
  parameter int unsigned MAX_SAMPLES = ssd_pkg::DEF_MAX_SAMPLES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic            s_tlast,
  output logic            m_tvalid,
  input  logic            m_tready,
  output ssd_pkg::dp_cmd_t cmd
);
  import ssd_pkg::*;

  localparam int MGW = mag_w(MAX_SAMPLES);
  localparam int PW  = prod_w(MAX_SAMPLES);
  localparam int RW  = (PW + 1) / 2;
  localparam int IW  = $clog2(PW + 1);

  ctrl_state_t state, state_next;
  logic [IW-1:0] cnt;
  logic [IW-1:0] phase_end;
  logic          phase_done;
  logic          take;
  logic          out_free;

  assign take     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (state)
      ST_DIV:  phase_end = IW'(PW);
      ST_SQRT: phase_end = IW'(RW);
      default: phase_end = IW'(MGW);
    endcase
  end

  assign phase_done = (cnt == phase_end);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM:   if (take && s_tlast) state_next = ST_SETTLE;
      ST_SETTLE:  state_next = ST_MUL_NQ;
      ST_MUL_NQ:  if (phase_done) state_next = ST_MUL_SS;
      ST_MUL_SS:  if (phase_done) state_next = ST_MUL_DEN;
      ST_MUL_DEN: if (phase_done) state_next = ST_DIV;
      ST_DIV:     if (phase_done) state_next = ST_SQRT;
      ST_SQRT:    if (phase_done) state_next = ST_RESULT;
      ST_RESULT:  if (out_free) state_next = ST_ACCUM;
      default:    state_next = ST_ACCUM;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = 1'b0;
    cmd.op   = OP_NONE;
    unique case (state)
      ST_ACCUM:   s_tready = 1'b1;
      ST_SETTLE:  cmd.op = OP_NONE;
      ST_MUL_NQ:  cmd.op = (cnt == '0) ? OP_LOAD_NQ   : OP_MUL_STEP;
      ST_MUL_SS:  cmd.op = (cnt == '0) ? OP_LOAD_SS   : OP_MUL_STEP;
      ST_MUL_DEN: cmd.op = (cnt == '0) ? OP_LOAD_DEN  : OP_MUL_STEP;
      ST_DIV:     cmd.op = (cnt == '0) ? OP_LOAD_DIV  : OP_DIV_STEP;
      ST_SQRT:    cmd.op = (cnt == '0) ? OP_LOAD_SQRT : OP_SQRT_STEP;
      ST_RESULT:  if (out_free) cmd.op = OP_WRITE_OUT;
      default:    cmd.op = OP_NONE;
    endcase
    cmd.take = take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACCUM;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else if (state != ST_ACCUM && state != ST_RESULT && state != ST_SETTLE) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.op == OP_WRITE_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/ssd_datapath.sv
// accumulators, shared shift-add multiplier, divider, square root and result register
`timescale 1ns / 1ps

module ssd_datapath #(
  parameter int unsigned MAX_SAMPLES = ssd_pkg::DEF_MAX_SAMPLES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ssd_pkg::dp_cmd_t                    cmd,
  input  logic signed [ssd_pkg::SAMPLE_W-1:0] sample,
  output logic [ssd_pkg::DEV_W-1:0]           deviation,
  output logic [ssd_pkg::COUNT_OUT_W-1:0]     sample_count,
  output ssd_pkg::status_t                    status
);
  import ssd_pkg::*;

  localparam int CW  = cnt_w(MAX_SAMPLES);
  localparam int MGW = mag_w(MAX_SAMPLES);
  localparam int SW  = sum_w(MAX_SAMPLES);
  localparam int QW  = sq_w(MAX_SAMPLES);
  localparam int PW  = prod_w(MAX_SAMPLES);
  localparam int DW  = 2 * CW;
  localparam int RW  = (PW + 1) / 2;

  // accumulation
  logic signed [SW-1:0] running_sum;
  logic [QW-1:0]        running_square_sum;
  logic [CW-1:0]        count;
  logic                 overflowed;
  logic [30:0]          sq_pipe;
  logic                 sq_valid;
  logic signed [31:0]   sq_full;

  // shared multiplier
  logic [PW-1:0]  mcand;
  logic [MGW-1:0] mplier;
  logic [PW-1:0]  prod;
  logic [PW-1:0]  nq;
  logic [MGW-1:0] sum_mag;

  // divider
  logic [DW-1:0]  den;
  logic [PW-1:0]  quo;
  logic [DW-1:0]  rem;
  logic [DW:0]    rem_sh;

  // square root
  logic [2*RW-1:0] sval;
  logic [RW-1:0]   root;
  logic [RW:0]     srem;
  logic [RW+1:0]   srem_sh;
  logic [RW+1:0]   trial;

  assign sq_full = sample * sample;
  assign sum_mag = running_sum[SW-1] ? MGW'(-running_sum) : MGW'(running_sum);
  assign rem_sh  = {rem, quo[PW-1]};
  assign srem_sh = {srem[RW-1:0], sval[2*RW-1 -: 2]};
  assign trial   = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum        <= '0;
      running_square_sum <= '0;
      count              <= '0;
      overflowed         <= 1'b0;
      sq_valid           <= 1'b0;
    end else if (cmd.op == OP_WRITE_OUT) begin
      running_sum        <= '0;
      running_square_sum <= '0;
      count              <= '0;
      overflowed         <= 1'b0;
      sq_valid           <= 1'b0;
    end else begin
      sq_valid <= 1'b0;
      if (sq_valid) begin
        running_square_sum <= running_square_sum + QW'(sq_pipe);
      end
      if (cmd.take) begin
        if (count < CW'(MAX_SAMPLES)) begin
          running_sum <= running_sum + SW'(sample);
          count       <= count + 1'b1;
          sq_valid    <= 1'b1;
        end else begin
          overflowed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_pipe <= sq_full[30:0];
  end

  // arithmetic sequence for the end of a block
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_NQ: begin
        mcand  <= PW'(running_square_sum);
        mplier <= MGW'(count);
        prod   <= '0;
      end
      OP_LOAD_SS: begin
        nq     <= prod;
        mcand  <= PW'(sum_mag);
        mplier <= sum_mag;
        prod   <= '0;
      end
      OP_LOAD_DEN: begin
        quo    <= (nq > prod) ? nq - prod : '0;
        mcand  <= PW'(count);
        mplier <= MGW'(count - 1'b1);
        prod   <= '0;
      end
      OP_MUL_STEP: begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end
      OP_LOAD_DIV: begin
        den <= prod[DW-1:0];
        rem <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= DW'(rem_sh - {1'b0, den});
          quo <= {quo[PW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DW-1:0];
          quo <= {quo[PW-2:0], 1'b0};
        end
      end
      OP_LOAD_SQRT: begin
        sval <= (2*RW)'(quo);
        srem <= '0;
        root <= '0;
      end
      OP_SQRT_STEP: begin
        if (srem_sh >= trial) begin
          srem <= (RW+1)'(srem_sh - trial);
          root <= {root[RW-2:0], 1'b1};
        end else begin
          srem <= srem_sh[RW:0];
          root <= {root[RW-2:0], 1'b0};
        end
        sval <= sval << 2;
      end
      OP_WRITE_OUT: begin
        sample_count <= COUNT_OUT_W'(count);
        if (count < CW'(2)) begin
          deviation <= '0;
          status    <= STAT_SHORT;
        end else begin
          deviation <= (root > RW'(16'hFFFF)) ? 16'hFFFF : root[DEV_W-1:0];
          status    <= overflowed ? STAT_OVERFLOW : STAT_OK;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/sample_standard_deviation.sv
// top level: sample standard deviation of a block of signed q8.8 samples
//
// input stream s_*: one sample per request in s_tdata, s_tlast marks the
// final sample of a block. samples are taken one per cycle while the block
// accumulates count, sum and sum of squares.
// output stream m_*: one request per block, carrying deviation (unsigned
// q8.8, floored), sample count and a status code.
// after the last sample the result is formed in order by the shared
// shift-add multiplier (three products), the one-bit-per-cycle divider
// and the two-bits-per-cycle square root; widths: MGW = 16+log2(MAX_SAMPLES),
// PW = 31+2*log2(MAX_SAMPLES), RW = ceil(PW/2).
// s_tready is low from the last sample until the result is registered.
// a result that is not taken holds in the output register while the next
// block is accumulated; a second result then waits until the first leaves.
// reset clears the accumulators and drops m_tvalid.
`timescale 1ns / 1ps

module sample_standard_deviation #(
  parameter int unsigned MAX_SAMPLES = ssd_pkg::DEF_MAX_SAMPLES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ssd_pkg::S_TDATA_W-1:0]  s_tdata,  // [15:0] sample
  input  logic                           s_tlast,  // last sample of the block
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ssd_pkg::M_TDATA_W-1:0]  m_tdata   // [15:0] deviation,
                                                   // [28:16] sample_count,
                                                   // [30:29] status, [31] zero
);
  import ssd_pkg::*;

  dp_cmd_t                 cmd;
  logic [DEV_W-1:0]        deviation;
  logic [COUNT_OUT_W-1:0]  sample_count;
  status_t                 status;

  // sequencer: handshakes and the end-of-block arithmetic steps
  ssd_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // accumulators and the shared arithmetic units
  ssd_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample       ($signed(s_tdata[SAMPLE_W-1:0])),
    .deviation    (deviation),
    .sample_count (sample_count),
    .status       (status)
  );

  // result fields packed from the low bit up
  assign m_tdata = {1'b0, status, sample_count, deviation};

endmodule

// File: rtl/ssd_checker.sv
// port-level assertions for the sample standard deviation block
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ssd_pkg::M_TDATA_W-1:0] m_tdata
);
  import ssd_pkg::*;

  logic in_last;
  logic out_stall;
  logic short_bad;

  assign in_last   = s_tvalid && s_tready && s_tlast;
  assign out_stall = m_tvalid && !m_tready;
  assign short_bad = m_tvalid && (m_tdata[30:29] == STAT_SHORT) && (m_tdata[15:0] != '0);

  // a stalled result stays offered
  `ASSERT_CLK(a_out_hold, out_stall |=> m_tvalid, "result dropped while stalled")

  // a stalled result keeps its payload
  `ASSERT_CLK(a_out_stable, out_stall |=> $stable(m_tdata), "result changed while stalled")

  // input closes after the last sample of a block
  `ASSERT_CLK(a_close_on_last, in_last |=> !s_tready, "input open after last sample")

  // a short block reports zero deviation
  `ASSERT_CLK(a_short_zero, !short_bad, "short block with nonzero deviation")

  // no result is offered right after reset
  `ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind sample_standard_deviation ssd_checker u_ssd_checker (.*);

// File: verif/sample_standard_deviation_tb.sv
// testbench for the sample standard deviation block: directed and random sample blocks
`timescale 1ns / 1ps

module sample_standard_deviation_tb;
  import ssd_pkg::*;

  localparam int unsigned MAX_N       = DEF_MAX_SAMPLES;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // idle wait once every owed result has been compared
  localparam int unsigned DRAIN_WAIT  = 400;

  typedef struct packed {
    logic [15:0] deviation;
    logic [12:0] sample_count;
    status_t     status;
  } dev_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // [15:0] sample
  logic                 s_tlast = 1'b0;  // last sample of the block
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;  // [15:0] deviation, [28:16] sample_count,
                                  // [30:29] status, [31] zero

  // idling odds in percent, changed per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  // block statistics as the hardware should hold them
  logic signed [28:0] blk_sum = '0;
  logic [43:0]        blk_sq_sum = '0;
  logic [12:0]        blk_n = '0;
  logic               blk_over = 1'b0;

  // results still owed by the block, oldest first
  dev_result_t owed_devs[$];
  dev_result_t want;

  sample_standard_deviation dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // integer square root, floored
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem = v;
    root = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // fold one accepted sample into the block; on the last one queue the result
  task automatic fold_sample(input logic signed [15:0] smp, input logic lst);
    logic signed [31:0] sq_term;
    logic [63:0]        n64;
    logic [63:0]        mag;
    logic [63:0]        nq;
    logic [63:0]        ss;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        root;
    dev_result_t        res;
    sq_term = smp * smp;
    if (blk_n < MAX_N) begin
      blk_sum = blk_sum + smp;
      blk_sq_sum = blk_sq_sum + 44'(unsigned'(sq_term));
      blk_n = blk_n + 1'b1;
    end else begin
      // samples past the maximum are dropped but flagged
      blk_over = 1'b1;
    end
    if (lst) begin
      n64 = 64'(blk_n);
      res.sample_count = blk_n;
      res.deviation = '0;
      if (blk_n < 2) begin
        res.status = STAT_SHORT;
      end else begin
        mag = (blk_sum < 0) ? 64'(-blk_sum) : 64'(blk_sum);
        ss = mag * mag;
        nq = n64 * 64'(blk_sq_sum);
        num = (nq > ss) ? nq - ss : 64'd0;
        den = n64 * (n64 - 1);
        root = floor_sqrt(num / den);
        res.deviation = (root > 64'd65535) ? 16'hFFFF : root[15:0];
        res.status = blk_over ? STAT_OVERFLOW : STAT_OK;
      end
      owed_devs.push_back(res);
      blk_sum = '0;
      blk_sq_sum = '0;
      blk_n = '0;
      blk_over = 1'b0;
    end
  endtask

  // offer one sample request at the falling edge, return at the falling edge after it is taken
  task automatic send_sample(input logic [15:0] smp, input logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    fold_sample(smp, lst);
    @(negedge clk);
  endtask

  // receiver: random backpressure, drawn each falling edge
  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // compare each result request with the oldest owed result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (owed_devs.size() == 0) begin
        $error("result request with none owed, m_tdata %h", m_tdata);
        err_count++;
      end else begin
        want = owed_devs.pop_front();
        if (m_tdata[15:0] !== want.deviation) begin
          $error("deviation: expected %0d, got %0d", want.deviation, m_tdata[15:0]);
          err_count++;
        end
        if (m_tdata[28:16] !== want.sample_count) begin
          $error("sample_count: expected %0d, got %0d", want.sample_count, m_tdata[28:16]);
          err_count++;
        end
        if (m_tdata[30:29] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[30:29]);
          err_count++;
        end
        if (m_tdata[31] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_tdata[31]);
          err_count++;
        end
      end
    end
  end

  // extremes, single-sample blocks, two-sample blocks and zero spread
  task automatic test_directed();
    send_sample(16'h8000, 1'b1);  // single most negative sample
    send_sample(16'h7FFF, 1'b1);  // single most positive sample
    send_sample(16'h8000, 1'b0);  // widest two-sample block
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b0);  // all zero
    send_sample(16'h0000, 1'b1);
    repeat (3) send_sample(16'h8000, 1'b0);  // constant block, no spread
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0100, 1'b0);  // +1.0, -1.0, +1.0, -1.0
    send_sample(16'hFF00, 1'b0);
    send_sample(16'h0100, 1'b0);
    send_sample(16'hFF00, 1'b1);
    send_sample(16'h5555, 1'b0);  // alternating bit patterns
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b1);
    send_sample(16'h0000, 1'b0);  // smallest nonzero spread
    send_sample(16'h0001, 1'b1);
  endtask

  // random blocks, mostly short, under the given idling odds
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned item_budget);
    int unsigned sent;
    int unsigned len;
    int unsigned shape;
    logic [15:0] base;
    logic [15:0] mask;
    logic [15:0] smp;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < item_budget) begin
      shape = $urandom_range(0, 19);
      if (shape < 2)       len = 1;
      else if (shape < 4)  len = $urandom_range(40, 200);
      else                 len = $urandom_range(2, 16);
      base = $urandom;
      // spread: full range, narrow around an offset, or constant
      case ($urandom_range(0, 3))
        0:       mask = 16'h0000;
        1:       mask = 16'h00FF;
        2:       mask = 16'h000F;
        default: mask = 16'hFFFF;
      endcase
      for (int unsigned i = 0; i < len; i++) begin
        smp = (mask == 16'hFFFF) ? 16'($urandom) : base + (16'($urandom) & mask);
        send_sample(smp, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_traffic(0, 0, 440);
    test_random_traffic(47, 0, 440);
    test_random_traffic(0, 47, 440);
    test_random_traffic(13, 13, 440);

    s_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (owed_devs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
